>>> sv/crf_pkg.sv
// ============================================================================
// crf_pkg
// Shared types and constants of the checked frame receiver.
// ============================================================================
package crf_pkg;

    localparam int MAX_COMMANDS = 16;
    localparam int CMD_IDX_W    = $clog2(MAX_COMMANDS);
    localparam int COUNT_W      = 5;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int WIN_LEN      = 4;

    localparam logic [7:0] HDR_XOR        = 8'hAA;
    localparam logic [7:0] DATA_XOR       = 8'h55;
    localparam logic [7:0] BROADCAST_ADDR = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MASTER_MODE   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COMMAND_COUNT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODES_LOW     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODES_HIGH    = 3'd5;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0]                  own_address;
        logic                        master_mode;
        logic [7:0]                  max_payload;
        logic [COUNT_W-1:0]          command_count;
        logic [MAX_COMMANDS*8-1:0]   command_codes;
    } cfg_t;

    typedef struct packed {
        logic                 hit;
        logic [CMD_IDX_W-1:0] index;
    } hdr_result_t;

endpackage

>>> sv/crf_if.sv
// ============================================================================
// crf_in_if / crf_out_if
// Valid/ready channels for received bytes and for receiver results.
// ============================================================================
interface crf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface crf_out_if;
    logic                            valid;
    logic                            ready;
    crf_pkg::kind_t                  result_kind;
    logic [7:0]                      frame_address;
    logic [crf_pkg::CMD_IDX_W-1:0]   command_index;
    logic [7:0]                      payload_length;
    logic [7:0]                      payload_byte;
    logic [7:0]                      byte_position;

    modport source (output valid, output result_kind, output frame_address,
                    output command_index, output payload_length,
                    output payload_byte, output byte_position, input ready);
    modport sink   (input valid, input result_kind, input frame_address,
                    input command_index, input payload_length,
                    input payload_byte, input byte_position, output ready);
endinterface

>>> sv/crf_cfg_regs.sv
// ============================================================================
// crf_cfg_regs
// Configuration register file written through a plain write port.
// ============================================================================
module crf_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [crf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [crf_pkg::CFG_DATA_W-1:0]     cfg_data,
    output crf_pkg::cfg_t                      cfg
);

    crf_pkg::cfg_t cfg_reg;
    crf_pkg::cfg_t cfg_next;

    localparam int HALF = crf_pkg::MAX_COMMANDS * 4;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                crf_pkg::CFG_OWN_ADDRESS:   cfg_next.own_address = cfg_data[7:0];
                crf_pkg::CFG_MASTER_MODE:   cfg_next.master_mode = cfg_data[0];
                crf_pkg::CFG_MAX_PAYLOAD:   cfg_next.max_payload = cfg_data[7:0];
                crf_pkg::CFG_COMMAND_COUNT:
                    cfg_next.command_count = cfg_data[crf_pkg::COUNT_W-1:0];
                crf_pkg::CFG_CODES_LOW:
                    cfg_next.command_codes[HALF-1:0] = cfg_data[HALF-1:0];
                crf_pkg::CFG_CODES_HIGH:
                    cfg_next.command_codes[2*HALF-1:HALF] = cfg_data[HALF-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{own_address:   8'h00,
                         master_mode:   1'b0,
                         max_payload:   8'hFF,
                         command_count: '0,
                         command_codes: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/crf_hdr_check.sv
// ============================================================================
// crf_hdr_check
// Header qualification: address, command table lookup, length and check byte.
// ============================================================================
module crf_hdr_check (
    input  logic [7:0]             hdr_address,
    input  logic [7:0]             hdr_command,
    input  logic [7:0]             hdr_length,
    input  logic [7:0]             hdr_check,
    input  crf_pkg::cfg_t          cfg,
    output crf_pkg::hdr_result_t   result
);

    logic                            addr_ok;
    logic                            cmd_found;
    logic [crf_pkg::CMD_IDX_W-1:0]   cmd_index;
    logic                            len_ok;
    logic                            chk_ok;
    logic [7:0]                      chk_sum;

    assign addr_ok = cfg.master_mode || (hdr_address == cfg.own_address)
                     || (hdr_address == crf_pkg::BROADCAST_ADDR);

    // Scan from the top so that the lowest matching entry wins.
    always_comb
    begin
        cmd_found = 1'b0;
        cmd_index = '0;
        for (int i = crf_pkg::MAX_COMMANDS - 1; i >= 0; i--)
        begin
            if ((cfg.command_count > crf_pkg::COUNT_W'(i))
                && (cfg.command_codes[8*i +: 8] == hdr_command))
            begin
                cmd_found = 1'b1;
                cmd_index = crf_pkg::CMD_IDX_W'(i);
            end
        end
    end

    assign len_ok  = (hdr_length <= cfg.max_payload);
    assign chk_sum = hdr_address + hdr_command + hdr_length;
    assign chk_ok  = (hdr_check == (chk_sum ^ crf_pkg::HDR_XOR));

    assign result.hit   = addr_ok && cmd_found && len_ok && chk_ok;
    assign result.index = cmd_index;

endmodule

>>> sv/checked_frame_receiver_core.sv
// ============================================================================
// checked_frame_receiver_core
// Byte-serial receiver for checked frames with tentative payload streaming.
// ============================================================================
// The receiver takes one byte per clock cycle as long as the result side does
// not stall. A byte first lands in an input register; from there the header
// check, payload sum and frame state update run as one pass and the result,
// if the byte gives one, is written to the output register, where it stays
// until it is transferred. The pass advances whenever the input register
// holds a byte and the output register is empty or being read; while a
// result waits, the input register keeps any byte it holds and, once it
// holds one, the byte input is stalled. Configuration writes take effect at
// the next clock edge and should only be made while no bytes are in flight.
module checked_frame_receiver_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [crf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [crf_pkg::CFG_DATA_W-1:0]     cfg_data,
    crf_in_if.sink                             rx,
    crf_out_if.source                          result
);

    crf_pkg::cfg_t          cfg;
    crf_pkg::hdr_result_t   hdr;

    // Input stage
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        advance;

    // Frame state
    logic [7:0]                      win_reg [crf_pkg::WIN_LEN];
    logic [7:0]                      win_next [crf_pkg::WIN_LEN];
    logic                            in_payload_reg, in_payload_next;
    logic [7:0]                      count_reg, count_next;
    logic [7:0]                      sum_reg, sum_next;
    logic [crf_pkg::CMD_IDX_W-1:0]   cmd_reg, cmd_next;

    // Output stage
    logic                            out_valid_reg;
    logic                            emit;
    crf_pkg::kind_t                  kind_next, kind_reg;
    logic [7:0]                      byte_next, byte_reg;
    logic [7:0]                      pos_next, pos_reg;
    logic [7:0]                      addr_reg, len_reg;
    logic [crf_pkg::CMD_IDX_W-1:0]   idx_reg;

    crf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The header is checked against the window as it stands after the shift.
    crf_hdr_check u_hdr (
        .hdr_address (win_reg[1]),
        .hdr_command (win_reg[2]),
        .hdr_length  (win_reg[3]),
        .hdr_check   (in_byte_reg),
        .cfg         (cfg),
        .result      (hdr)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    always_comb
    begin
        win_next        = win_reg;
        in_payload_next = in_payload_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        cmd_next        = cmd_reg;
        emit            = 1'b0;
        kind_next       = crf_pkg::KIND_ACCEPT;
        byte_next       = '0;
        pos_next        = '0;
        if (!in_payload_reg)
        begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = win_reg[3];
            win_next[3] = in_byte_reg;
            if (hdr.hit)
            begin
                cmd_next = hdr.index;
                if (win_reg[3] == 8'd0)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    in_payload_next = 1'b1;
                    count_next      = '0;
                    sum_next        = '0;
                end
            end
        end
        else if (count_reg < win_reg[2])
        begin
            emit       = 1'b1;
            kind_next  = crf_pkg::KIND_PAYLOAD;
            byte_next  = in_byte_reg;
            pos_next   = count_reg;
            count_next = count_reg + 8'd1;
            sum_next   = sum_reg + in_byte_reg;
        end
        else
        begin
            emit            = 1'b1;
            in_payload_next = 1'b0;
            if (in_byte_reg != (sum_reg ^ crf_pkg::DATA_XOR))
            begin
                kind_next = crf_pkg::KIND_REJECT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < crf_pkg::WIN_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
            in_payload_reg <= 1'b0;
            count_reg      <= '0;
            sum_reg        <= '0;
            cmd_reg        <= '0;
        end
        else if (advance)
        begin
            win_reg        <= win_next;
            in_payload_reg <= in_payload_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            cmd_reg        <= cmd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            pos_reg  <= pos_next;
            addr_reg <= win_next[0];
            len_reg  <= win_next[2];
            idx_reg  <= cmd_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.result_kind    = kind_reg;
    assign result.frame_address  = addr_reg;
    assign result.command_index  = idx_reg;
    assign result.payload_length = len_reg;
    assign result.payload_byte   = byte_reg;
    assign result.byte_position  = pos_reg;

endmodule

>>> test/tb_checked_frame_receiver_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_checked_frame_receiver_core
// Self-checking bench for the checked frame receiver. A behavioral decoder
// follows every transferred byte and queues the results that the byte must
// produce; each result transfer is compared field by field with the oldest
// queued result. Directed frames cover the header checks, the data check,
// the window that survives a frame and the register corner cases. Random
// frames then run under several register settings, with random idle on both
// channels in all but the last random setting.
// ============================================================================
module tb_checked_frame_receiver_core;

    import crf_pkg::*;

    // Indexes past the end of the register list; writes there change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_GUARD   = 5000;

    typedef struct packed {
        kind_t                kind;
        logic [7:0]           address;
        logic [CMD_IDX_W-1:0] command;
        logic [7:0]           length;
        logic [7:0]           data;
        logic [7:0]           position;
    } frame_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    crf_in_if  rx_ch ();
    crf_out_if res_ch ();

    checked_frame_receiver_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .result    (res_ch)
    );

    // Register copies used by the decoder.
    logic [7:0]         cfg_own;
    logic               cfg_master;
    logic [7:0]         cfg_max_len;
    logic [COUNT_W-1:0] cfg_cmd_count;
    logic [7:0]         cmd_table [MAX_COMMANDS];

    // Decoder state.
    logic [7:0]           win [WIN_LEN];
    logic                 in_frame;
    logic [7:0]           rx_count;
    logic [7:0]           data_sum;
    logic [CMD_IDX_W-1:0] cur_cmd;

    frame_result_t pending_results [$];

    int  fail_count;
    int  bytes_sent;
    int  payload_seen;
    int  accept_seen;
    int  reject_seen;
    int  settings_used;
    bit  sender_gaps;
    bit  receiver_stalls;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results still expected", pending_results.size());
        $display("tb_checked_frame_receiver_core failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------------
    function automatic void reset_decoder();
        cfg_own       = 8'h00;
        cfg_master    = 1'b0;
        cfg_max_len   = 8'hFF;
        cfg_cmd_count = '0;
        for (int i = 0; i < MAX_COMMANDS; i++)
            cmd_table[i] = 8'h00;
        for (int i = 0; i < WIN_LEN; i++)
            win[i] = 8'h00;
        in_frame = 1'b0;
        rx_count = 8'h00;
        data_sum = 8'h00;
        cur_cmd  = '0;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_OWN_ADDRESS:   cfg_own = value[7:0];
            CFG_MASTER_MODE:   cfg_master = value[0];
            CFG_MAX_PAYLOAD:   cfg_max_len = value[7:0];
            CFG_COMMAND_COUNT: cfg_cmd_count = value[COUNT_W-1:0];
            CFG_CODES_LOW:
                for (int i = 0; i < 8; i++)
                    cmd_table[i] = value[8*i +: 8];
            CFG_CODES_HIGH:
                for (int i = 0; i < 8; i++)
                    cmd_table[8+i] = value[8*i +: 8];
            default: ;
        endcase
    endfunction

    function automatic void push_result(input kind_t kind, input logic [7:0] data,
                                        input logic [7:0] pos);
        frame_result_t r;
        r.kind     = kind;
        r.address  = win[0];
        r.command  = cur_cmd;
        r.length   = win[2];
        r.data     = data;
        r.position = pos;
        pending_results.push_back(r);
    endfunction

    function automatic int table_size();
        return (cfg_cmd_count > MAX_COMMANDS) ? MAX_COMMANDS : int'(cfg_cmd_count);
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        logic [7:0] chk;
        int         hit;
        if (in_frame)
        begin
            if (rx_count < win[2])
            begin
                push_result(KIND_PAYLOAD, b, rx_count);
                rx_count = rx_count + 8'd1;
                data_sum = data_sum + b;
            end
            else
            begin
                in_frame = 1'b0;
                if (b == (data_sum ^ DATA_XOR))
                    push_result(KIND_ACCEPT, 8'h00, 8'h00);
                else
                    push_result(KIND_REJECT, 8'h00, 8'h00);
            end
            return;
        end
        win[0] = win[1];
        win[1] = win[2];
        win[2] = win[3];
        win[3] = b;
        hit = -1;
        for (int i = 0; i < table_size(); i++)
            if (hit < 0 && cmd_table[i] == win[1])
                hit = i;
        chk = (win[0] + win[1] + win[2]) ^ HDR_XOR;
        if (!cfg_master && win[0] != cfg_own && win[0] != BROADCAST_ADDR)
            return;
        if (hit < 0 || win[2] > cfg_max_len || win[3] != chk)
            return;
        cur_cmd = CMD_IDX_W'(hit);
        if (win[2] == 8'h00)
            push_result(KIND_ACCEPT, 8'h00, 8'h00);
        else
        begin
            in_frame = 1'b1;
            rx_count = 8'h00;
            data_sum = 8'h00;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        apply_register(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (sender_gaps && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            rx_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        decode_byte(b);
        bytes_sent++;
    endtask

    // Header, payload and data check; the payload is random or alternates
    // between all zeros and all ones.
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                              input logic [7:0] len, input bit hdr_good,
                              input bit data_good, input bit extreme);
        logic [7:0] chk;
        logic [7:0] sum;
        logic [7:0] b;
        chk = (addr + cmd + len) ^ HDR_XOR;
        if (!hdr_good)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(addr);
        send_byte(cmd);
        send_byte(len);
        send_byte(chk);
        if (len == 8'h00)
            return;
        sum = 8'h00;
        for (int i = 0; i < int'(len); i++)
        begin
            b = extreme ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        chk = sum ^ DATA_XOR;
        if (!data_good)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    // Stops the byte stream and lets the block empty before registers change.
    task automatic wait_idle();
        int guard;
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_results.size() != 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time,
                     pending_results.size());
            fail_count++;
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left   = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0 && receiver_stalls && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 10);
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result();
        frame_result_t want;
        if (pending_results.size() == 0)
        begin
            $display("%0t ns: unexpected result, kind %0d address 0x%02h position %0d",
                     $time, res_ch.result_kind, res_ch.frame_address,
                     res_ch.byte_position);
            fail_count++;
            return;
        end
        want = pending_results.pop_front();
        compare_field("result_kind", 8'(want.kind), 8'(res_ch.result_kind));
        compare_field("frame_address", want.address, res_ch.frame_address);
        compare_field("command_index", 8'(want.command), 8'(res_ch.command_index));
        compare_field("payload_length", want.length, res_ch.payload_length);
        compare_field("payload_byte", want.data, res_ch.payload_byte);
        compare_field("byte_position", want.position, res_ch.byte_position);
        case (want.kind)
            KIND_PAYLOAD: payload_seen++;
            KIND_ACCEPT:  accept_seen++;
            default:      reject_seen++;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            check_result();
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset the command table is empty, so even a header that is
    // correct in every other respect must be ignored.
    task automatic test_empty_table();
        settings_used++;
        send_frame(8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0);
        send_frame(BROADCAST_ADDR, 8'h00, 8'h02, 1'b1, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_header_checks();
        settings_used++;
        write_reg(CFG_OWN_ADDRESS, 64'h12);
        write_reg(CFG_MASTER_MODE, 64'h0);
        write_reg(CFG_MAX_PAYLOAD, 64'd16);
        write_reg(CFG_COMMAND_COUNT, 64'd3);
        // Entry 2 repeats entry 0, so code 0x10 must report index 0.
        write_reg(CFG_CODES_LOW, 64'h7766_5544_3310_2010);
        write_reg(CFG_CODES_HIGH, 64'h0);
        send_frame(8'h12, 8'h20, 8'd2, 1'b1, 1'b1, 1'b0);
        send_frame(BROADCAST_ADDR, 8'h10, 8'd0, 1'b1, 1'b1, 1'b0);
        send_frame(8'h12, 8'h10, 8'd16, 1'b1, 1'b1, 1'b1);
        send_frame(8'h12, 8'h20, 8'd3, 1'b1, 1'b0, 1'b0);
        send_frame(8'h13, 8'h20, 8'd0, 1'b1, 1'b1, 1'b0);
        send_frame(8'h00, 8'h20, 8'd0, 1'b1, 1'b1, 1'b0);
        send_frame(8'h12, 8'h33, 8'd0, 1'b1, 1'b1, 1'b0);
        send_frame(8'h12, 8'h10, 8'd17, 1'b1, 1'b1, 1'b1);
        send_frame(8'h12, 8'h20, 8'd1, 1'b0, 1'b1, 1'b0);
        send_frame(8'h12, 8'h20, 8'd1, 1'b1, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic test_master_and_window();
        logic [7:0] k;
        logic [7:0] sum;
        logic [7:0] b;
        settings_used++;
        write_reg(CFG_OWN_ADDRESS, 64'd254);
        write_reg(CFG_MASTER_MODE, 64'h1);
        write_reg(CFG_MAX_PAYLOAD, 64'd255);
        // A count above the table size acts as a full table.
        write_reg(CFG_COMMAND_COUNT, 64'd31);
        write_reg(CFG_CODES_LOW, 64'h0706_0504_0302_0100);
        write_reg(CFG_CODES_HIGH, 64'h100E_0D0C_0B0A_0908);
        // Zero-length frame on the last table entry, then one byte that turns
        // the leftover window into a new header with length k.
        send_frame(8'h99, 8'h10, 8'd0, 1'b1, 1'b1, 1'b0);
        k = (8'h99 + 8'h10) ^ HDR_XOR;
        send_byte((8'h10 + k) ^ HDR_XOR);
        sum = 8'h00;
        for (int i = 0; i < int'(k); i++)
        begin
            b = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        send_byte(sum ^ DATA_XOR);
        send_frame(8'h5A, 8'h05, 8'd255, 1'b1, 1'b1, 1'b1);
        wait_idle();
        write_reg(CFG_SPARE_LO, '1);
        write_reg(CFG_SPARE_HI, '1);
        send_frame(8'h00, 8'h00, 8'd1, 1'b1, 1'b1, 1'b0);
        send_frame(8'h37, 8'h0E, 8'd2, 1'b1, 1'b0, 1'b0);
        wait_idle();
    endtask

    task automatic test_zero_max_payload();
        settings_used++;
        write_reg(CFG_OWN_ADDRESS, 64'h0);
        write_reg(CFG_MASTER_MODE, 64'h0);
        write_reg(CFG_MAX_PAYLOAD, 64'h0);
        write_reg(CFG_COMMAND_COUNT, 64'd1);
        write_reg(CFG_CODES_LOW, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00 | 64'hAB);
        write_reg(CFG_CODES_HIGH, {$urandom, $urandom});
        send_frame(8'h00, 8'hAB, 8'd0, 1'b1, 1'b1, 1'b0);
        send_frame(8'h00, 8'hAB, 8'd1, 1'b1, 1'b1, 1'b0);
        send_frame(BROADCAST_ADDR, 8'hAB, 8'd0, 1'b1, 1'b1, 1'b0);
        wait_idle();
    endtask

    task automatic random_setup(input int mode);
        logic [7:0]         own;
        logic [7:0]         max_len;
        logic [COUNT_W-1:0] cnt;
        logic               master;
        own     = 8'($urandom_range(0, 254));
        max_len = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(4, 40)) : 8'($urandom);
        cnt     = COUNT_W'($urandom_range(1, MAX_COMMANDS));
        master  = 1'($urandom_range(0, 1));
        if (mode == 0)
        begin
            own     = 8'd254;
            max_len = 8'd255;
            cnt     = COUNT_W'(MAX_COMMANDS);
            master  = 1'b0;
        end
        else if (mode == 1)
        begin
            own     = 8'd0;
            max_len = 8'd0;
            cnt     = COUNT_W'(1);
            master  = 1'b1;
        end
        settings_used++;
        write_reg(CFG_OWN_ADDRESS, 64'(own));
        write_reg(CFG_MASTER_MODE, 64'(master));
        write_reg(CFG_MAX_PAYLOAD, 64'(max_len));
        write_reg(CFG_COMMAND_COUNT, 64'(cnt));
        write_reg(CFG_CODES_LOW, {$urandom, $urandom});
        write_reg(CFG_CODES_HIGH, {$urandom, $urandom});
    endtask

    // Mostly well-formed frames with random content, mixed with noise bytes,
    // foreign addresses, unknown codes, long lengths and broken checks.
    task automatic random_phase(input int mode, input int budget, input bit calm);
        int         start;
        int         r;
        logic [7:0] addr;
        logic [7:0] cmd;
        logic [7:0] len;
        sender_gaps     = !calm;
        receiver_stalls = !calm;
        random_setup(mode);
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                continue;
            end
            r = $urandom_range(0, 99);
            addr = (r < 45) ? cfg_own : (r < 70) ? BROADCAST_ADDR : 8'($urandom);
            cmd = ($urandom_range(0, 99) < 85) ? cmd_table[$urandom_range(0, table_size() - 1)]
                                               : 8'($urandom);
            r = $urandom_range(0, 99);
            if (r < 75)
                len = 8'($urandom_range(0, 6));
            else if (r < 98)
                len = 8'($urandom_range(7, 30));
            else
                len = 8'($urandom);
            if (len > cfg_max_len && $urandom_range(0, 9) != 0)
                len = 8'($urandom_range(0, cfg_max_len));
            send_frame(addr, cmd, len, $urandom_range(0, 9) != 0,
                       $urandom_range(0, 3) != 0, 1'b0);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < 6; p++)
            random_phase(p, 60, p == 5);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_OWN_ADDRESS;
        cfg_data        = '0;
        rx_ch.valid     = 1'b0;
        rx_ch.rx_byte   = 8'h00;
        fail_count      = 0;
        bytes_sent      = 0;
        payload_seen    = 0;
        accept_seen     = 0;
        reject_seen     = 0;
        settings_used   = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        reset_decoder();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_header_checks();
        test_master_and_window();
        test_zero_max_payload();
        test_random_traffic();

        $display("Sent %0d bytes under %0d register settings.", bytes_sent, settings_used);
        $display("Checked %0d payload bytes, %0d accepted and %0d rejected frames.",
                 payload_seen, accept_seen, reject_seen);
        if (fail_count == 0)
            $display("tb_checked_frame_receiver_core passed");
        else
            $display("tb_checked_frame_receiver_core failed");
        $finish;
    end

endmodule
